>>> src/tisp_pkg.sv
package tisp_pkg;

	localparam logic [7:0] B_IAC  = 8'd255;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_DO   = 8'd253;
	localparam logic [7:0] B_WONT = 8'd252;
	localparam logic [7:0] B_WILL = 8'd251;
	localparam logic [7:0] B_SB   = 8'd250;
	localparam logic [7:0] B_GA   = 8'd249;
	localparam logic [7:0] B_NOP  = 8'd241;
	localparam logic [7:0] B_SE   = 8'd240;
	localparam logic [7:0] MCCP1_OPT = 8'd85;

	localparam logic [2:0] K_TEXT   = 3'd0;
	localparam logic [2:0] K_REPLY  = 3'd1;
	localparam logic [2:0] K_NEG    = 3'd2;
	localparam logic [2:0] K_SUB    = 3'd3;
	localparam logic [2:0] K_SUBEND = 3'd4;

	localparam logic [1:0] V_DO   = 2'd0;
	localparam logic [1:0] V_DONT = 2'd1;
	localparam logic [1:0] V_WILL = 2'd2;
	localparam logic [1:0] V_WONT = 2'd3;

	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

	typedef enum logic [2:0] {
		ST_NORMAL,
		ST_IAC,
		ST_DO,
		ST_DONT,
		ST_WILL,
		ST_WONT,
		ST_SB,
		ST_SB_IAC
	} parse_state_t;

	// Commands from the front parser; each expands to one or more results.
	typedef enum logic [2:0] {
		CMD_TEXT1,   // text value
		CMD_TEXT2,   // text 255, text value
		CMD_GA,      // "<IAC><GA>"
		CMD_NEG,     // negotiation event, optional three reply bytes
		CMD_SUB1,    // subneg value
		CMD_SUB2,    // subneg 255, subneg value
		CMD_SUBEND   // subneg end, option in value
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] value;
		logic [1:0] verb;
		logic       refuse;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] value;
		logic [1:0] verb;
		logic       last;
	} res_t;

	function automatic logic [7:0] ga_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0: c = 8'h3C; // <
			4'd1: c = 8'h49; // I
			4'd2: c = 8'h41; // A
			4'd3: c = 8'h43; // C
			4'd4: c = 8'h3E; // >
			4'd5: c = 8'h3C; // <
			4'd6: c = 8'h47; // G
			4'd7: c = 8'h41; // A
			default: c = 8'h3E; // >
		endcase
		return c;
	endfunction

	function automatic logic [3:0] cmd_len(input cmd_t cmd);
		logic [3:0] n;
		unique case (cmd.op)
			CMD_TEXT2, CMD_SUB2: n = 4'd2;
			CMD_GA:              n = 4'd9;
			CMD_NEG:             n = cmd.refuse ? 4'd4 : 4'd1;
			default:             n = 4'd1;
		endcase
		return n;
	endfunction

	function automatic res_t cmd_item(input cmd_t cmd, input logic [3:0] idx);
		res_t r;
		r.kind  = K_TEXT;
		r.value = cmd.value;
		r.verb  = 2'd0;
		r.last  = (idx == cmd_len(cmd) - 4'd1);
		unique case (cmd.op)
			CMD_TEXT1: r.kind = K_TEXT;
			CMD_TEXT2: begin
				r.kind = K_TEXT;
				if (idx == 4'd0) r.value = B_IAC;
			end
			CMD_GA: begin
				r.kind  = K_TEXT;
				r.value = ga_char(idx);
			end
			CMD_NEG: begin
				if (idx == 4'd0) begin
					r.kind = K_NEG;
					r.verb = cmd.verb;
				end else begin
					r.kind = K_REPLY;
					if (idx == 4'd1) r.value = B_IAC;
					else if (idx == 4'd2) r.value = (cmd.verb == V_DO) ? B_WONT : B_DONT;
				end
			end
			CMD_SUB1: r.kind = K_SUB;
			CMD_SUB2: begin
				r.kind = K_SUB;
				if (idx == 4'd0) r.value = B_IAC;
			end
			default: r.kind = K_SUBEND;
		endcase
		return r;
	endfunction

endpackage

>>> src/telnet_iac_stream_parser_top.sv
// Telnet IAC stream parser.
//
// Input channel: one received byte per transfer on rx_byte (push / full).
// Result channel: a queue-style port (empty / pop); each result carries
// out_kind (text, reply to peer, negotiation event, subneg byte, subneg
// end), out_value, out_verb and last, which marks the final result of a
// byte. Silent bytes (IAC, verbs, SB, NOP, IAC inside subneg) give none.
//
// A byte passes the command queue, the current-command register and the
// result register. Throughput: one byte per cycle unless full; results
// leave one per cycle while pop is high; a byte with several (IAC GA gives
// nine, a refused DO/WILL four) holds the result side until all leave.
// The front parser keeps taking bytes into a four-entry command queue
// until it fills, so full rises only under long expansions or stalls.
//
// When pop stays low, the result register holds and backpressure reaches
// full through the command queue; nothing is dropped.
// Reset: parser returns to the text state, queues empty, answer_refusals=1.
// APB register 0 (address 0), bit 0: answer_refusals.
module telnet_iac_stream_parser_top
	import tisp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	// results
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  out_kind,
	output logic [7:0]  out_value,
	output logic [1:0]  out_verb,
	output logic        last,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic answer_refusals_q;
	logic byte_xfer;
	logic cmd_valid;
	cmd_t cmd_in, cmd_out;
	logic q_empty, q_pop;

	// Config register; user writes only while the parser is idle, not enforced.
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {31'd0, answer_refusals_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answer_refusals_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr == 2'd0) begin
			answer_refusals_q <= pwdata[0];
		end
	end

	// A byte transfers whenever the command queue has room.
	assign byte_xfer = push && !full;

	tisp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_xfer),
		.rx_byte         (rx_byte),
		.answer_refusals (answer_refusals_q),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd_in)
	);

	tisp_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (byte_xfer && cmd_valid),
		.wr_cmd (cmd_in),
		.full   (full),
		.pop    (q_pop),
		.rd_cmd (cmd_out),
		.empty  (q_empty)
	);

	// Back end expands each command into results, one per cycle unless pop stalls.
	tisp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_cmd     (cmd_out),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.out_kind  (out_kind),
		.out_value (out_value),
		.out_verb  (out_verb),
		.last      (last)
	);

endmodule

>>> src/tisp_front.sv
module tisp_front
	import tisp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic [7:0] rx_byte,
	input  logic       answer_refusals,
	output logic       cmd_valid,
	output cmd_t       cmd
);

	parse_state_t state_q, state_d;
	logic [1:0] sub_count_q, sub_count_d;
	logic [7:0] sub_first_q, sub_first_d;
	logic [7:0] sub_second_q, sub_second_d;
	logic [1:0] cnt_mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_NORMAL;
			sub_count_q  <= 2'd0;
			sub_first_q  <= 8'd0;
			sub_second_q <= 8'd0;
		end else if (byte_valid) begin
			state_q      <= state_d;
			sub_count_q  <= sub_count_d;
			sub_first_q  <= sub_first_d;
			sub_second_q <= sub_second_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		sub_count_d  = sub_count_q;
		sub_first_d  = sub_first_q;
		sub_second_d = sub_second_q;
		cnt_mid      = sub_count_q;
		cmd_valid    = 1'b0;
		cmd.op       = CMD_TEXT1;
		cmd.value    = rx_byte;
		cmd.verb     = 2'd0;
		cmd.refuse   = 1'b0;
		unique case (state_q)
			ST_NORMAL: begin
				if (rx_byte == B_IAC) state_d = ST_IAC;
				else cmd_valid = 1'b1;
			end
			ST_IAC: begin
				state_d = ST_NORMAL;
				priority if (rx_byte == B_DO) state_d = ST_DO;
				else if (rx_byte == B_DONT) state_d = ST_DONT;
				else if (rx_byte == B_WILL) state_d = ST_WILL;
				else if (rx_byte == B_WONT) state_d = ST_WONT;
				else if (rx_byte == B_SB) begin
					state_d      = ST_SB;
					sub_count_d  = 2'd0;
					sub_first_d  = 8'd0;
					sub_second_d = 8'd0;
				end else if (rx_byte == B_GA) begin
					cmd_valid = 1'b1;
					cmd.op    = CMD_GA;
				end else if (rx_byte == B_IAC) begin
					cmd_valid = 1'b1;
				end else begin
					// NOP is dropped, anything else goes out as IAC + byte
					cmd_valid = (rx_byte != B_NOP);
					cmd.op    = CMD_TEXT2;
				end
			end
			ST_DO, ST_DONT, ST_WILL, ST_WONT: begin
				state_d   = ST_NORMAL;
				cmd_valid = 1'b1;
				cmd.op    = CMD_NEG;
				cmd.verb  = 2'(state_q - ST_DO);
				cmd.refuse = answer_refusals && (state_q == ST_DO || state_q == ST_WILL);
			end
			ST_SB: begin
				if (rx_byte == B_IAC) begin
					state_d = ST_SB_IAC;
				end else if (rx_byte == B_SE && sub_count_q == 2'd2 &&
				             sub_first_q == MCCP1_OPT && sub_second_q == B_WILL) begin
					state_d   = ST_NORMAL;
					cmd_valid = 1'b1;
					cmd.op    = CMD_SUBEND;
					cmd.value = sub_first_q;
				end else begin
					cmd_valid = 1'b1;
					cmd.op    = CMD_SUB1;
					if (sub_count_q == 2'd0) sub_first_d = rx_byte;
					if (sub_count_q == 2'd1) sub_second_d = rx_byte;
					if (sub_count_q != 2'd3) sub_count_d = sub_count_q + 2'd1;
				end
			end
			ST_SB_IAC: begin
				cmd_valid = 1'b1;
				if (rx_byte == B_SE) begin
					state_d   = ST_NORMAL;
					cmd.op    = CMD_SUBEND;
					cmd.value = sub_first_q;
				end else begin
					// doubled pair: collect 255, then the byte
					state_d = ST_SB;
					cmd.op  = CMD_SUB2;
					if (sub_count_q == 2'd0) sub_first_d = B_IAC;
					if (sub_count_q == 2'd1) sub_second_d = B_IAC;
					if (sub_count_q != 2'd3) cnt_mid = sub_count_q + 2'd1;
					if (cnt_mid == 2'd0) sub_first_d = rx_byte;
					if (cnt_mid == 2'd1) sub_second_d = rx_byte;
					sub_count_d = (cnt_mid != 2'd3) ? cnt_mid + 2'd1 : cnt_mid;
				end
			end
		endcase
	end

endmodule

>>> src/tisp_cmd_fifo.sv
module tisp_cmd_fifo
	import tisp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic pop,
	output cmd_t rd_cmd,
	output logic empty
);

	cmd_t mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMD_PTR_W:0]   count_q;
	logic do_push, do_pop;

	assign full    = (count_q == (CMD_PTR_W+1)'(CMD_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> src/tisp_back.sv
module tisp_back
	import tisp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       q_cmd,
	input  logic       q_empty,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output logic [2:0] out_kind,
	output logic [7:0] out_value,
	output logic [1:0] out_verb,
	output logic       last
);

	cmd_t       cur_q;
	logic       cur_valid_q;
	logic [3:0] idx_q;
	logic       out_valid_q;
	res_t       out_q;
	res_t       item;
	logic       out_ready, step, cur_done;

	assign item      = cmd_item(cur_q, idx_q);
	assign out_ready = !out_valid_q || pop;
	assign step      = cur_valid_q && out_ready;
	assign cur_done  = step && item.last;
	assign q_pop     = (!cur_valid_q || cur_done) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) out_valid_q <= cur_valid_q;
			if (step) idx_q <= item.last ? 4'd0 : idx_q + 4'd1;
			if (cur_done) cur_valid_q <= 1'b0;
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 4'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_cmd;
		if (step) out_q <= item;
	end

	assign empty     = !out_valid_q;
	assign out_kind  = out_q.kind;
	assign out_value = out_q.value;
	assign out_verb  = out_q.verb;
	assign last      = out_q.last;

endmodule

>>> src/tisp_checker.sv
module tisp_checker
	import tisp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [2:0] out_kind,
	input logic [7:0] out_value,
	input logic [1:0] out_verb,
	input logic       last
);

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_kind <= K_SUBEND))
		else $error("result kind out of range");

	a_verb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_kind != K_NEG) |-> (out_verb == 2'd0))
		else $error("verb set on non-negotiation result");

	a_subend_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (out_kind == K_SUBEND || out_kind == K_SUB)) |->
		(out_kind == K_SUB || last))
		else $error("subneg end not marked last");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_kind) && $stable(out_value) &&
		$stable(out_verb) && $stable(last)))
		else $error("stalled result changed");

endmodule

bind telnet_iac_stream_parser_top tisp_checker u_tisp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.empty     (empty),
	.pop       (pop),
	.out_kind  (out_kind),
	.out_value (out_value),
	.out_verb  (out_verb),
	.last      (last)
);

>>> verif/telnet_iac_stream_parser_top_tb.sv
module telnet_iac_stream_parser_top_tb;
	import tisp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// register map: one register, answer_refusals, at byte address 0
	localparam int REG_ANSWER_REFUSALS = 0;
	localparam logic [1:0] ADDR_ANSWER_REFUSALS = 2'(REG_ANSWER_REFUSALS * 4);

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;       // idle margin after the last expected result
	localparam int RANDOM_PHASE_BYTES = 50;
	localparam int MAX_REPORTS = 50;

	localparam logic [1:0] NO_VERB = 2'd0;
	// text that replaces IAC GA, first character in the top byte
	localparam logic [71:0] GA_TEXT = "<IAC><GA>";
	localparam res_t NO_CHECK = '0;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  rx_byte;
	logic        empty;
	logic        pop;
	logic [2:0]  out_kind;
	logic [7:0]  out_value;
	logic [1:0]  out_verb;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	telnet_iac_stream_parser_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.rx_byte (rx_byte),
		.empty   (empty),
		.pop     (pop),
		.out_kind(out_kind),
		.out_value(out_value),
		.out_verb(out_verb),
		.last    (last),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Parser mirror: state and config as the block should hold them.
	// ------------------------------------------------------------------
	parse_state_t rx_state;
	logic [1:0]   sb_count;     // saturates at 3
	logic [7:0]   sb_opt;       // first subneg byte
	logic [7:0]   sb_second;    // second subneg byte
	logic         refuse_en;

	res_t       byte_results[$];      // results of the byte just decoded
	res_t       expected_results[$];  // in flight, oldest first
	logic [7:0] stim_bytes[$];

	int  errors;
	int  results_checked;
	int  bytes_sent;
	int  cycles;
	int  res_wait;
	bit  sender_steady;
	bit  receiver_steady;

	task automatic report(input string what);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("mismatch at %0t ns: %s", $time, what);
	endtask

	function automatic int draw_wait();
		return ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 16)) : 0;
	endfunction

	function automatic void add_result(input logic [2:0] kind, input logic [7:0] value,
			input logic [1:0] verb);
		res_t r;
		r.kind  = kind;
		r.value = value;
		r.verb  = verb;
		r.last  = 1'b0;
		byte_results.push_back(r);
	endfunction

	function automatic void sb_collect(input logic [7:0] v);
		if (sb_count == 2'd0)
			sb_opt = v;
		else if (sb_count == 2'd1)
			sb_second = v;
		if (sb_count != 2'd3)
			sb_count = sb_count + 2'd1;
		add_result(K_SUB, v, NO_VERB);
	endfunction

	// Advance the mirror by one received byte; results land in byte_results.
	function automatic void decode_byte(input logic [7:0] b);
		logic [1:0] verb;
		byte_results.delete();
		case (rx_state)
			ST_NORMAL: begin
				if (b == B_IAC)
					rx_state = ST_IAC;
				else
					add_result(K_TEXT, b, NO_VERB);
			end
			ST_IAC: begin
				rx_state = ST_NORMAL;
				case (b)
					B_DO:   rx_state = ST_DO;
					B_DONT: rx_state = ST_DONT;
					B_WILL: rx_state = ST_WILL;
					B_WONT: rx_state = ST_WONT;
					B_SB: begin
						sb_count  = 2'd0;
						sb_opt    = 8'd0;
						sb_second = 8'd0;
						rx_state  = ST_SB;
					end
					B_GA: begin
						for (int i = 0; i < 9; i++)
							add_result(K_TEXT, GA_TEXT[71 - 8 * i -: 8], NO_VERB);
					end
					B_IAC: add_result(K_TEXT, B_IAC, NO_VERB);
					B_NOP: ;
					default: begin
						// unknown command: both bytes go out as text
						add_result(K_TEXT, B_IAC, NO_VERB);
						add_result(K_TEXT, b, NO_VERB);
					end
				endcase
			end
			ST_DO, ST_DONT, ST_WILL, ST_WONT: begin
				case (rx_state)
					ST_DO:   verb = V_DO;
					ST_DONT: verb = V_DONT;
					ST_WILL: verb = V_WILL;
					default: verb = V_WONT;
				endcase
				// event first, then the refusal
				add_result(K_NEG, b, verb);
				if (refuse_en && (rx_state == ST_DO || rx_state == ST_WILL)) begin
					add_result(K_REPLY, B_IAC, NO_VERB);
					add_result(K_REPLY, (rx_state == ST_DO) ? B_WONT : B_DONT, NO_VERB);
					add_result(K_REPLY, b, NO_VERB);
				end
				rx_state = ST_NORMAL;
			end
			ST_SB: begin
				if (b == B_IAC) begin
					rx_state = ST_SB_IAC;
				end else if (b == B_SE && sb_count == 2'd2 && sb_opt == MCCP1_OPT &&
						sb_second == B_WILL) begin
					// compression v1 closes with a bare SE
					add_result(K_SUBEND, sb_opt, NO_VERB);
					rx_state = ST_NORMAL;
				end else begin
					sb_collect(b);
				end
			end
			default: begin
				if (b == B_SE) begin
					add_result(K_SUBEND, sb_opt, NO_VERB);
					rx_state = ST_NORMAL;
				end else begin
					sb_collect(B_IAC);
					sb_collect(b);
					rx_state = ST_SB;
				end
			end
		endcase
		if (byte_results.size() > 0)
			byte_results[byte_results.size() - 1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Byte side. push stays high across back-to-back transfers; it is
	// only lowered when a gap is drawn or the stream drains, so it never
	// gets two updates in one step.
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input bit typed, input res_t first);
		int gap;
		gap = sender_steady ? 0 : draw_wait();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		bytes_sent++;
		decode_byte(b);
		// rows with a hand-written first result are checked against that
		if (typed) begin
			if (byte_results.size() == 0)
				byte_results.push_back(first);
			else
				byte_results[0] = first;
		end
		foreach (byte_results[i])
			expected_results.push_back(byte_results[i]);
	endtask

	// stop feeding, let every result come out, then a little margin
	task automatic drain();
		push <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// APB: setup, access, then idle with psel low before returning, so that
	// back-to-back calls never lower and raise psel in the same step.
	// ------------------------------------------------------------------
	task automatic reg_write(input logic [1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_ANSWER_REFUSALS)
			refuse_en = data[0];
		@(posedge clk);
	endtask

	task automatic reg_read_check(input logic [1:0] addr, input logic [31:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			report($sformatf("register read at %0d: got %h, want %h", addr, prdata, want));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Random stream, built from well-formed telnet sequences with random
	// content, plus some raw noise biased toward the command bytes.
	// ------------------------------------------------------------------
	function automatic void add_sequence();
		int pick;
		int n;
		logic [7:0] v;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			stim_bytes.push_back(8'($urandom_range(0, 254)));
		end else if (pick < 37) begin
			stim_bytes.push_back(B_IAC);
			case ($urandom_range(0, 3))
				0: stim_bytes.push_back(B_IAC);
				1: stim_bytes.push_back(B_NOP);
				2: stim_bytes.push_back(B_GA);
				default: stim_bytes.push_back(8'($urandom_range(0, 255)));
			endcase
		end else if (pick < 62) begin
			stim_bytes.push_back(B_IAC);
			stim_bytes.push_back(8'(B_WILL + $urandom_range(0, 3)));
			stim_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (pick < 80) begin
			stim_bytes.push_back(B_IAC);
			stim_bytes.push_back(B_SB);
			n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				v = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 4) == 0) begin
					// escaped pair inside the block
					stim_bytes.push_back(B_IAC);
					if (v == B_SE)
						v = B_IAC;
				end else if (v == B_IAC) begin
					stim_bytes.push_back(B_IAC);
				end
				stim_bytes.push_back(v);
			end
			stim_bytes.push_back(B_IAC);
			stim_bytes.push_back(B_SE);
		end else if (pick < 90) begin
			// compression v1 start, sometimes with extra bytes so SE is data
			stim_bytes.push_back(B_IAC);
			stim_bytes.push_back(B_SB);
			stim_bytes.push_back(MCCP1_OPT);
			stim_bytes.push_back(B_WILL);
			if ($urandom_range(0, 2) == 0) begin
				stim_bytes.push_back(8'($urandom_range(0, 254)));
				stim_bytes.push_back(B_SE);
				stim_bytes.push_back(B_IAC);
			end
			stim_bytes.push_back(B_SE);
		end else begin
			if ($urandom_range(0, 1) == 0)
				stim_bytes.push_back(8'($urandom_range(0, 255)));
			else
				stim_bytes.push_back(8'($urandom_range(B_SE, B_IAC)));
		end
	endfunction

	task automatic run_random_phase(input int n_bytes);
		stim_bytes.delete();
		while (stim_bytes.size() < n_bytes)
			add_sequence();
		sender_steady   = ($urandom_range(0, 3) == 0);
		receiver_steady = ($urandom_range(0, 3) == 0);
		foreach (stim_bytes[i])
			send_byte(stim_bytes[i], 1'b0, NO_CHECK);
		drain();
	endtask

	// ------------------------------------------------------------------
	// Result side: pop stalls a drawn number of cycles after each
	// transfer; every transfer is checked against the oldest expectation.
	// Outputs are read at the edge itself, i.e. their pre-edge values.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_side
		res_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					report($sformatf("result with nothing expected: kind %0d value %h",
						out_kind, out_value));
				end else begin
					want = expected_results.pop_front();
					if (out_kind !== want.kind)
						report($sformatf("out_kind %0d, want %0d", out_kind, want.kind));
					if (out_value !== want.value)
						report($sformatf("out_value %h, want %h", out_value, want.value));
					if (out_verb !== want.verb)
						report($sformatf("out_verb %0d, want %0d", out_verb, want.verb));
					if (last !== want.last)
						report($sformatf("last %b, want %b", last, want.last));
					results_checked++;
				end
				res_wait = receiver_steady ? 0 : draw_wait();
			end else if (res_wait > 0) begin
				res_wait--;
			end
			pop <= (res_wait == 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Directed bytes, run with refusals at their reset value (on).
	// A typed row gives the first result of that byte by hand.
	// ------------------------------------------------------------------
	typedef struct {
		logic [7:0] rx;
		bit         typed;
		res_t       first;
	} stim_row_t;

	localparam int N_DIRECTED = 37;

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{8'h00,  1'b1, '{K_TEXT,   8'h00, NO_VERB, 1'b1}},  // lowest text byte
		'{B_IAC,  1'b0, NO_CHECK},                           // silent IAC
		'{B_IAC,  1'b1, '{K_TEXT,   B_IAC, NO_VERB, 1'b1}},  // IAC IAC -> 255
		'{B_IAC,  1'b0, NO_CHECK},
		'{B_NOP,  1'b0, NO_CHECK},                           // dropped
		'{B_IAC,  1'b0, NO_CHECK},
		'{B_GA,   1'b0, NO_CHECK},                           // nine text bytes
		'{B_IAC,  1'b0, NO_CHECK},
		'{8'h7F,  1'b0, NO_CHECK},                           // unknown command
		'{B_IAC,  1'b0, NO_CHECK},
		'{B_DO,   1'b0, NO_CHECK},
		'{8'h00,  1'b1, '{K_NEG,    8'h00, V_DO,    1'b0}},  // event, then refusal
		'{B_IAC,  1'b0, NO_CHECK},
		'{B_DONT, 1'b0, NO_CHECK},
		'{8'hFF,  1'b1, '{K_NEG,    8'hFF, V_DONT,  1'b1}},
		'{B_IAC,  1'b0, NO_CHECK},
		'{B_WILL, 1'b0, NO_CHECK},
		'{8'h55,  1'b0, NO_CHECK},
		'{B_IAC,  1'b0, NO_CHECK},
		'{B_WONT, 1'b0, NO_CHECK},
		'{8'h01,  1'b1, '{K_NEG,    8'h01, V_WONT,  1'b1}},
		'{B_IAC,  1'b0, NO_CHECK},                           // empty subneg
		'{B_SB,   1'b0, NO_CHECK},
		'{B_IAC,  1'b0, NO_CHECK},
		'{B_SE,   1'b1, '{K_SUBEND, 8'h00, NO_VERB, 1'b1}},
		'{B_IAC,  1'b0, NO_CHECK},                           // compression v1
		'{B_SB,   1'b0, NO_CHECK},
		'{MCCP1_OPT, 1'b1, '{K_SUB, MCCP1_OPT, NO_VERB, 1'b1}},
		'{B_WILL, 1'b0, NO_CHECK},
		'{B_SE,   1'b1, '{K_SUBEND, MCCP1_OPT, NO_VERB, 1'b1}},
		'{B_IAC,  1'b0, NO_CHECK},                           // doubled IAC kept
		'{B_SB,   1'b0, NO_CHECK},
		'{8'h18,  1'b0, NO_CHECK},
		'{B_IAC,  1'b0, NO_CHECK},
		'{B_IAC,  1'b0, NO_CHECK},
		'{B_IAC,  1'b0, NO_CHECK},
		'{B_SE,   1'b1, '{K_SUBEND, 8'h18, NO_VERB, 1'b1}}
	};

	initial begin
		arst_n  = 1'b0;
		push    = 1'b0;
		rx_byte = 8'd0;
		pop     = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = 2'd0;
		pwdata  = 32'd0;

		rx_state        = ST_NORMAL;
		sb_count        = 2'd0;
		sb_opt          = 8'd0;
		sb_second       = 8'd0;
		refuse_en       = 1'b1;
		errors          = 0;
		results_checked = 0;
		bytes_sent      = 0;
		cycles          = 0;
		res_wait        = 0;
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// refusals come up enabled
		reg_read_check(ADDR_ANSWER_REFUSALS, 32'd1);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].first);
		run_random_phase(RANDOM_PHASE_BYTES);

		// refusals off
		reg_write(ADDR_ANSWER_REFUSALS, 32'h0000_0000);
		reg_read_check(ADDR_ANSWER_REFUSALS, 32'd0);
		run_random_phase(RANDOM_PHASE_BYTES);

		// all ones: only bit 0 counts
		reg_write(ADDR_ANSWER_REFUSALS, 32'hFFFF_FFFF);
		reg_read_check(ADDR_ANSWER_REFUSALS, 32'd1);
		run_random_phase(RANDOM_PHASE_BYTES);

		// upper bits set, bit 0 clear
		reg_write(ADDR_ANSWER_REFUSALS, 32'hFFFF_FFFE);
		reg_read_check(ADDR_ANSWER_REFUSALS, 32'd0);
		run_random_phase(RANDOM_PHASE_BYTES);

		$display("covered %0d received bytes and %0d results in %0d cycles", bytes_sent,
			results_checked, cycles);
		$display("refusal replies on and off, config writes with upper bits set and clear");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> sim.f
src/tisp_pkg.sv
src/tisp_front.sv
src/tisp_cmd_fifo.sv
src/tisp_back.sv
src/telnet_iac_stream_parser_top.sv
src/tisp_checker.sv
verif/telnet_iac_stream_parser_top_tb.sv
